// ===== src/msfd_pkg.sv =====
package msfd_pkg;

	localparam int TAG_W = 8;
	localparam int TIME_IN_W = 16;
	localparam int STAT_W = 16;
	localparam int SUM_W = 32;
	localparam int ACT_W = 4;
	localparam int APB_W = 32;

	localparam int IN_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;
	localparam logic REG_ACTIVE_SERVERS = 1'b0;

	localparam logic [STAT_W-1:0] STAT_MAX = '1;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TIME_IN_W-1:0] stamp;
		logic [TIME_IN_W-1:0] service;
	} req_t;

	typedef struct packed {
		logic arrival;
		req_t req;
	} tick_item_t;

endpackage

// ===== src/multi_server_fifo_dispatcher.sv =====
// Multi-server FIFO dispatcher. Each input item is one time tick that may carry a request
// (tag, arrival stamp, service time). Servers whose busy time ends on the tick are freed,
// the request joins a waiting queue, and the active servers are scanned from index zero,
// each free one taking the queue head.
// The input channel is push/full and the result channel is empty/pop. A tick produces one
// result per dispatch, or a single status result when nothing is dispatched, and last
// marks the final result of the tick. The APB port holds the number of active servers.
// A tick takes the dispatch engine through the release and prepare states, then one scan
// step per server scanned; the scan stops after the last dispatch. With the engine idle,
// the first result of a tick is pushed into the result queue at the scan step of its first
// dispatch, or at the status step when nothing is dispatched.
// A two-entry tick queue takes new items while the engine works, and a four-entry result
// queue holds finished results. When the receiver stops popping, the engine stalls once
// the result queue is full, then the tick queue fills and full rises.
// Reset clears all servers to free, the counters to zero, the tick to one and the active
// server count to eight. Waiting entries need no clearing.
module multi_server_fifo_dispatcher import msfd_pkg::*; #(
	parameter int MAX_SERVERS = 8,
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [APB_W-1:0] pwdata,
	output logic [APB_W-1:0] prdata,
	output logic pready,
	input logic push,
	output logic full,
	input logic arrival_valid,
	input logic [TAG_W-1:0] request_tag,
	input logic [TIME_IN_W-1:0] arrival_stamp,
	input logic [TIME_IN_W-1:0] service_time,
	output logic empty,
	input logic pop,
	output logic dispatched,
	output logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] server_index,
	output logic [TAG_W-1:0] dispatched_tag,
	output logic [STAT_W-1:0] wait_time,
	output logic [STAT_W-1:0] server_served_count,
	output logic [STAT_W-1:0] max_wait,
	output logic [SUM_W-1:0] wait_sum,
	output logic [$clog2(QUEUE_DEPTH + 1)-1:0] queue_count,
	output logic arrival_dropped,
	output logic last
);

	localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RES_W = 1 + SRV_W + TAG_W + 3 * STAT_W + SUM_W + CNT_W + 2;

	logic [ACT_W-1:0] act_q;
	logic cfg_wr;
	logic avail;
	logic take;
	tick_item_t item;
	logic res_space;
	logic res_push;
	logic [RES_W-1:0] res_in;
	logic [RES_W-1:0] res_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SERVERS);
	assign prdata = (paddr[2] == REG_ACTIVE_SERVERS) ? APB_W'(act_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_RESET;
		end else if (cfg_wr) begin
			act_q <= pwdata[ACT_W-1:0];
		end
	end

	msfd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.arrival_valid(arrival_valid),
		.request_tag(request_tag),
		.arrival_stamp(arrival_stamp),
		.service_time(service_time),
		.avail(avail),
		.take(take),
		.item(item)
	);

	msfd_back #(
		.MAX_SERVERS(MAX_SERVERS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.act(act_q),
		.avail(avail),
		.take(take),
		.item(item),
		.res_space(res_space),
		.res_push(res_push),
		.res_data(res_in)
	);

	msfd_res_q #(
		.W(RES_W)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.data_in(res_in),
		.space(res_space),
		.pop(pop),
		.empty(empty),
		.data_out(res_out)
	);

	assign {dispatched, server_index, dispatched_tag, wait_time, server_served_count,
		max_wait, wait_sum, queue_count, arrival_dropped, last} = res_out;

`ifndef SYNTH
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_space)
		else $error("Result written while the result queue is full.");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !dispatched) |-> last)
		else $error("A status item is not the final item of its tick.");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !dispatched) |-> (server_index == '0 && dispatched_tag == '0 &&
		wait_time == '0 && server_served_count == '0))
		else $error("A status item carries dispatch fields.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (queue_count <= CNT_W'(QUEUE_DEPTH)))
		else $error("Waiting count exceeds the queue depth.");
`endif

endmodule

// ===== src/msfd_front.sv =====
module msfd_front import msfd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic arrival_valid,
	input logic [TAG_W-1:0] request_tag,
	input logic [TIME_IN_W-1:0] arrival_stamp,
	input logic [TIME_IN_W-1:0] service_time,
	output logic avail,
	input logic take,
	output tick_item_t item
);

	localparam int PW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;

	tick_item_t slot_q [IN_DEPTH];
	tick_item_t in_item;
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] cnt_q;
	logic accept;
	logic pop_item;

	assign full = (cnt_q == (PW+1)'(IN_DEPTH));
	assign avail = (cnt_q != '0);
	assign accept = push && !full;
	assign pop_item = take && avail;
	assign item = slot_q[rd_q];

	// A zero service time occupies a server for one tick.
	always_comb begin
		in_item.arrival = arrival_valid;
		in_item.req.tag = request_tag;
		in_item.req.stamp = arrival_stamp;
		in_item.req.service = (service_time == '0) ? TIME_IN_W'(1) : service_time;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= (wr_q == PW'(IN_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop_item) begin
				rd_q <= (rd_q == PW'(IN_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (accept && !pop_item) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (!accept && pop_item) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== src/msfd_res_q.sv =====
module msfd_res_q import msfd_pkg::*; #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] data_in,
	output logic space,
	input logic pop,
	output logic empty,
	output logic [W-1:0] data_out
);

	localparam int PW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

	logic [W-1:0] slot_q [RES_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign space = (cnt_q != (PW+1)'(RES_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && space;
	assign do_pop = pop && !empty;
	assign data_out = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(RES_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(RES_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== src/msfd_back.sv =====
module msfd_back import msfd_pkg::*; #(
	parameter int MAX_SERVERS = 8,
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS = 16,
	localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int RES_W = 1 + SRV_W + TAG_W + 3 * STAT_W + SUM_W + CNT_W + 2
) (
	input logic clk,
	input logic arst_n,
	input logic [ACT_W-1:0] act,
	input logic avail,
	output logic take,
	input tick_item_t item,
	input logic res_space,
	output logic res_push,
	output logic [RES_W-1:0] res_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int NW = ($clog2(MAX_SERVERS + 1) > ACT_W) ? $clog2(MAX_SERVERS + 1) : ACT_W;
	localparam int WW = (TIME_BITS > TIME_IN_W) ? TIME_BITS : TIME_IN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RELEASE,
		ST_PREP,
		ST_SCAN
	} state_t;

	state_t state_q;
	tick_item_t item_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [MAX_SERVERS-1:0] busy_q;
	logic [TIME_BITS-1:0] until_q [MAX_SERVERS];
	logic [STAT_W-1:0] served_q [MAX_SERVERS];
	logic [SUM_W-1:0] sum_q;
	logic [STAT_W-1:0] max_q;
	logic [SRV_W-1:0] idx_q;
	logic any_q;
	logic dropped_q;

	req_t mem [QUEUE_DEPTH];
	req_t rd_q;

	logic [NW-1:0] act_ext;
	logic [NW-1:0] n;
	logic in_range;
	logic disp;
	logic [CNT_W-1:0] count_after;
	logic [MAX_SERVERS-1:0] later_free;
	logic later;
	logic emit;
	logic step;
	logic queue_full;
	logic mem_we;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] rd_addr;
	logic [WW-1:0] tick_ext;
	logic [WW-1:0] stamp_ext;
	logic [WW-1:0] wait_w;
	logic [STAT_W-1:0] wait16;
	logic [SUM_W:0] sum_w;
	logic [SUM_W-1:0] sum_n;
	logic [STAT_W-1:0] max_n;
	logic [STAT_W-1:0] served_n;
	logic [TIME_BITS-1:0] until_n;

	assign act_ext = NW'(act);
	assign n = (act_ext > NW'(MAX_SERVERS)) ? NW'(MAX_SERVERS) : act_ext;
	assign in_range = (NW'(idx_q) < n);
	assign disp = in_range && !busy_q[idx_q] && (count_q != '0);
	assign count_after = count_q - CNT_W'(disp);

	always_comb begin
		for (int j = 0; j < MAX_SERVERS; j++) begin
			later_free[j] = !busy_q[j] && (NW'(j) > NW'(idx_q)) && (NW'(j) < n);
		end
	end

	// The next free active server above this one takes the head if any entry remains.
	assign later = (count_after != '0) && (|later_free);
	assign emit = disp || (!later && !any_q);
	assign step = (state_q == ST_SCAN) && res_space;
	assign res_push = step && emit;
	assign take = (state_q == ST_IDLE) && avail;

	assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign mem_we = (state_q == ST_RELEASE) && item_q.arrival && !queue_full;
	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
	assign rd_addr = (step && disp) ? head_inc : head_q;

	assign tick_ext = WW'(tick_q);
	assign stamp_ext = WW'(rd_q.stamp);
	assign wait_w = (tick_ext >= stamp_ext) ? tick_ext - stamp_ext : '0;
	assign wait16 = (wait_w > WW'(STAT_MAX)) ? STAT_MAX : wait_w[STAT_W-1:0];
	assign sum_w = {1'b0, sum_q} + (SUM_W+1)'(wait_w);
	assign sum_n = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
	assign max_n = (wait_w > WW'(max_q)) ? wait16 : max_q;
	assign served_n = (served_q[idx_q] == STAT_MAX) ? served_q[idx_q]
		: served_q[idx_q] + STAT_W'(1);
	assign until_n = TIME_BITS'(tick_ext + WW'(rd_q.service));

	assign res_data = {
		disp,
		disp ? idx_q : SRV_W'(0),
		disp ? rd_q.tag : TAG_W'(0),
		disp ? wait16 : STAT_W'(0),
		disp ? served_n : STAT_W'(0),
		disp ? max_n : max_q,
		disp ? sum_n : sum_q,
		count_after,
		dropped_q,
		!later
	};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= item_q.req;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q <= TIME_BITS'(1);
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			busy_q <= '0;
			for (int j = 0; j < MAX_SERVERS; j++) begin
				until_q[j] <= '0;
				served_q[j] <= '0;
			end
			sum_q <= '0;
			max_q <= '0;
			idx_q <= '0;
			any_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_RELEASE;
					end
				end
				ST_RELEASE: begin
					for (int j = 0; j < MAX_SERVERS; j++) begin
						if ((NW'(j) < n) && busy_q[j] && (until_q[j] == tick_q)) begin
							busy_q[j] <= 1'b0;
						end
					end
					dropped_q <= item_q.arrival && queue_full;
					if (mem_we) begin
						tail_q <= tail_inc;
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					idx_q <= '0;
					any_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (step) begin
						if (disp) begin
							head_q <= head_inc;
							count_q <= count_after;
							busy_q[idx_q] <= 1'b1;
							until_q[idx_q] <= until_n;
							served_q[idx_q] <= served_n;
							sum_q <= sum_n;
							max_q <= max_n;
							any_q <= 1'b1;
						end
						if (later) begin
							idx_q <= idx_q + SRV_W'(1);
						end else begin
							tick_q <= tick_q + TIME_BITS'(1);
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== verif/tb_multi_server_fifo_dispatcher.sv =====
module tb_multi_server_fifo_dispatcher import msfd_pkg::*;;

	localparam int SERVER_COUNT = 8;
	localparam int WAIT_SLOTS = 64;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int REPORT_LIMIT = 50;

	typedef struct packed {
		logic disp;
		logic [2:0] server;
		logic [TAG_W-1:0] tag;
		logic [STAT_W-1:0] wait_ticks;
		logic [STAT_W-1:0] served;
		logic [STAT_W-1:0] worst;
		logic [SUM_W-1:0] total;
		logic [6:0] queued;
		logic dropped;
		logic closes_tick;
	} dispatch_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [APB_W-1:0] pwdata;
	logic [APB_W-1:0] prdata;
	logic pready;
	logic push;
	logic full;
	logic arrival_valid;
	logic [TAG_W-1:0] request_tag;
	logic [TIME_IN_W-1:0] arrival_stamp;
	logic [TIME_IN_W-1:0] service_time;
	logic empty;
	logic pop;
	logic dispatched;
	logic [2:0] server_index;
	logic [TAG_W-1:0] dispatched_tag;
	logic [STAT_W-1:0] wait_time;
	logic [STAT_W-1:0] server_served_count;
	logic [STAT_W-1:0] max_wait;
	logic [SUM_W-1:0] wait_sum;
	logic [6:0] queue_count;
	logic arrival_dropped;
	logic last;

	logic [15:0] tick_now;
	req_t waiting_req [WAIT_SLOTS];
	logic [5:0] head_slot;
	logic [5:0] tail_slot;
	int waiting_n;
	logic [15:0] release_tick [SERVER_COUNT];
	logic server_busy [SERVER_COUNT];
	logic [15:0] served_n [SERVER_COUNT];
	logic [31:0] wait_total;
	logic [15:0] worst_wait;
	logic [ACT_W-1:0] active_setting;
	dispatch_t pending_dispatches [$];
	dispatch_t oldest;

	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit tx_idling = 1'b1;
	bit rx_idling = 1'b1;

	multi_server_fifo_dispatcher u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tick_item_t make_tick(input logic arv, input logic [TAG_W-1:0] tag,
			input logic [TIME_IN_W-1:0] stamp, input logic [TIME_IN_W-1:0] svc);
		tick_item_t item;
		item.arrival = arv;
		item.req.tag = tag;
		item.req.stamp = stamp;
		item.req.service = svc;
		return item;
	endfunction

	// Frees servers, queues the arrival and hands the queue head to each free active server.
	function automatic void dispatch_tick(input tick_item_t item);
		dispatch_t tick_out [SERVER_COUNT];
		req_t head;
		logic dropped;
		logic [15:0] waited;
		logic [32:0] widened;
		int scan_n;
		int produced;
		scan_n = (active_setting > SERVER_COUNT) ? SERVER_COUNT : int'(active_setting);
		produced = 0;
		dropped = 1'b0;
		for (int i = 0; i < scan_n; i++) begin
			if (server_busy[i] && release_tick[i] == tick_now) begin
				server_busy[i] = 1'b0;
			end
		end
		if (item.arrival) begin
			if (waiting_n >= WAIT_SLOTS) begin
				dropped = 1'b1;
			end else begin
				waiting_req[tail_slot] = item.req;
				if (item.req.service == '0) begin
					waiting_req[tail_slot].service = 16'd1;
				end
				tail_slot++;
				waiting_n++;
			end
		end
		for (int i = 0; i < scan_n; i++) begin
			if (!server_busy[i] && waiting_n != 0) begin
				head = waiting_req[head_slot];
				head_slot++;
				waiting_n--;
				waited = (tick_now >= head.stamp) ? tick_now - head.stamp : 16'd0;
				widened = {1'b0, wait_total} + 33'(waited);
				wait_total = widened[32] ? '1 : widened[31:0];
				if (waited > worst_wait) begin
					worst_wait = waited;
				end
				if (served_n[i] != STAT_MAX) begin
					served_n[i]++;
				end
				release_tick[i] = tick_now + head.service;
				server_busy[i] = 1'b1;
				tick_out[produced] = '{1'b1, 3'(i), head.tag, waited, served_n[i], worst_wait,
					wait_total, 7'(waiting_n), dropped, 1'b0};
				produced++;
			end
		end
		if (produced == 0) begin
			tick_out[0] = '{1'b0, 3'd0, 8'd0, 16'd0, 16'd0, worst_wait, wait_total,
				7'(waiting_n), dropped, 1'b0};
			produced = 1;
		end
		tick_out[produced-1].closes_tick = 1'b1;
		for (int i = 0; i < produced; i++) begin
			pending_dispatches.push_back(tick_out[i]);
		end
		tick_now++;
	endfunction

	function automatic tick_item_t random_tick();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			return make_tick(1'b0, 8'($urandom), 16'($urandom), 16'($urandom));
		end
		if (pick < 18) begin
			return make_tick(1'b1, 8'($urandom), 16'($urandom), 16'($urandom_range(1, 40)));
		end
		if (pick < 22) begin
			return make_tick(1'b1, 8'($urandom), tick_now - 16'($urandom_range(0, 8)), 16'd0);
		end
		return make_tick(1'b1, 8'($urandom),
			tick_now - 16'($urandom_range(0, 30)) + 16'($urandom_range(0, 2)),
			16'($urandom_range(1, 24)));
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
			end
		end
	endtask

	task automatic send_tick(input tick_item_t item);
		if (tx_idling && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		arrival_valid <= item.arrival;
		request_tag <= item.req.tag;
		arrival_stamp <= item.req.stamp;
		service_time <= item.req.service;
		do @(posedge clk); while (full);
		dispatch_tick(item);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_dispatches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_active(input logic [ACT_W-1:0] setting);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_ACTIVE_SERVERS);
		pwdata <= APB_W'(setting);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		active_setting = setting;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", APB_W'(setting), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_extremes();
		send_tick(make_tick(1'b0, 8'h00, 16'h0000, 16'h0000));
		send_tick(make_tick(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF));
		send_tick(make_tick(1'b1, 8'h00, 16'h0000, 16'h0001));
		send_tick(make_tick(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF));
		send_tick(make_tick(1'b1, 8'h5A, 16'h0000, 16'h0000));
		send_tick(make_tick(1'b1, 8'hA5, tick_now, 16'h0002));
		send_tick(make_tick(1'b1, 8'h3C, tick_now + 16'd1, 16'h0001));
		send_tick(make_tick(1'b0, 8'h00, 16'h0000, 16'h0000));
		wait_drained();
	endtask

	// With no server scanned the queue fills up and the last arrivals are dropped.
	task automatic test_full_queue();
		write_active(4'd0);
		for (int i = 0; i < WAIT_SLOTS + 3; i++) begin
			send_tick(make_tick(1'b1, 8'($urandom), tick_now - 16'($urandom_range(0, 3)),
				16'($urandom_range(1, 4))));
		end
		wait_drained();
		write_active(4'd15);
		repeat (12) send_tick(make_tick(1'b0, 8'h00, 16'h0000, 16'h0000));
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_active(4'd8);
		hold_left = 300;
		for (int i = 0; i < 30; i++) begin
			send_tick(make_tick(1'b1, 8'($urandom), tick_now, 16'($urandom_range(1, 3))));
		end
		wait_drained();
	endtask

	// Stamps above the tick give zero waits, and one release time wraps to zero.
	task automatic test_tick_wrap();
		logic [15:0] svc;
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		write_active(4'd8);
		for (int i = 0; i < 60; i++) begin
			svc = (i == 30) ? 16'd0 - tick_now : 16'($urandom_range(1, 12));
			send_tick(make_tick(1'b1, 8'($urandom), (i % 2 == 0) ? 16'h0000 : 16'hFFF0, svc));
		end
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		logic [ACT_W-1:0] setting;
		for (int phase = 0; phase < 7; phase++) begin
			setting = ACT_W'($urandom_range(1, 9));
			if (phase == 6) begin
				tx_idling = 1'b0;
				rx_idling = 1'b0;
				setting = 4'd8;
			end
			write_active(setting);
			repeat (34) send_tick(random_tick());
			wait_drained();
		end
	endtask

	initial begin
		int gap_left;
		gap_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (gap_left > 0) begin
				pop <= 1'b0;
				gap_left--;
			end else if (rx_idling && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				gap_left = $urandom_range(0, 12);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_dispatches.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%0t: result with none expected, tag expected none, actual 0x%0h",
						$time, dispatched_tag);
				end
			end else begin
				oldest = pending_dispatches.pop_front();
				check_field("dispatched", oldest.disp, dispatched);
				check_field("server_index", oldest.server, server_index);
				check_field("dispatched_tag", oldest.tag, dispatched_tag);
				check_field("wait_time", oldest.wait_ticks, wait_time);
				check_field("server_served_count", oldest.served, server_served_count);
				check_field("max_wait", oldest.worst, max_wait);
				check_field("wait_sum", oldest.total, wait_sum);
				check_field("queue_count", oldest.queued, queue_count);
				check_field("arrival_dropped", oldest.dropped, arrival_dropped);
				check_field("last", oldest.closes_tick, last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		tick_now = 16'd1;
		head_slot = '0;
		tail_slot = '0;
		waiting_n = 0;
		wait_total = '0;
		worst_wait = '0;
		active_setting = ACT_RESET;
		for (int i = 0; i < SERVER_COUNT; i++) begin
			release_tick[i] = '0;
			server_busy[i] = 1'b0;
			served_n[i] = '0;
		end
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		push <= 1'b0;
		arrival_valid <= 1'b0;
		request_tag <= '0;
		arrival_stamp <= '0;
		service_time <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_full_queue();
		test_backpressure();
		test_tick_wrap();
		test_random_traffic();
		wait_drained();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/msfd_pkg.sv
src/msfd_front.sv
src/msfd_res_q.sv
src/msfd_back.sv
src/multi_server_fifo_dispatcher.sv
verif/tb_multi_server_fifo_dispatcher.sv
